>>> sv/preemptive_priority_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// preemptive priority scheduler assertion macros
// immediate-cycle and next-cycle implication checks on clock, gated by reset
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the preemptive priority scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int TICK_W              = 16;
   localparam int PRI_W               = 8;
   localparam int SLOT_W              = 4;
   localparam int CNT_W               = 5;
   localparam int EVENT_W             = 3;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;
   localparam logic [CNT_W-1:0]  DONE_MAX = '1;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [EVENT_W-1:0] {
      EV_LOAD     = 3'd0,
      EV_NONE     = 3'd1,
      EV_CONTINUE = 3'd2,
      EV_DISPATCH = 3'd3,
      EV_PREEMPT  = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic commit_load;
      logic commit_tick;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

>>> sv/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// sequencer for load and tick transactions: scan, flush, decide and commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_ready,
   input  pps_pkg::status_type status,
   output pps_pkg::cmd_type    cmd
);
   import pps_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_TICK) ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.capture    = req_valid;
            cmd.scan_start = req_valid;
         end
         ST_LOAD: begin
            cmd.commit_load = status.out_free;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_FLUSH: begin
         end
         ST_DECIDE: begin
            cmd.commit_tick = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// task tables, scan compare unit, run state, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_datapath #(
   parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pps_pkg::cmd_type            cmd,
   output pps_pkg::status_type         status,
   input  logic [pps_pkg::SLOT_W-1:0]  req_task_slot,
   input  logic [pps_pkg::TICK_W-1:0]  req_arrival_tick,
   input  logic [pps_pkg::PRI_W-1:0]   req_task_priority,
   input  logic                        req_running_done,
   input  logic                        csr_write_enable,
   input  logic [pps_pkg::CNT_W-1:0]   csr_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pps_pkg::EVENT_W-1:0] rsp_event_code,
   output logic                        rsp_running_valid,
   output logic [pps_pkg::SLOT_W-1:0]  rsp_running_task,
   output logic [pps_pkg::SLOT_W-1:0]  rsp_preempted_task,
   output logic                        rsp_first_start,
   output logic                        rsp_finished_valid,
   output logic [pps_pkg::TICK_W-1:0]  rsp_tick_now,
   output logic                        rsp_all_done
);
   import pps_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int LW    = ($clog2(MAX_ENTRIES + 1) > CNT_W) ? $clog2(MAX_ENTRIES + 1) : CNT_W;
   localparam logic [LW-1:0]    MAX_L    = LW'(MAX_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   // captured transaction
   logic [SLOT_W-1:0] slot_ff;
   logic [TICK_W-1:0] arr_ff;
   logic [PRI_W-1:0]  pri_ff;
   logic              done_ff;

   logic [CNT_W-1:0]  task_count_ff;

   // task tables
   logic [TICK_W-1:0] arr_mem [MAX_ENTRIES];
   logic [PRI_W-1:0]  pri_mem [MAX_ENTRIES];
   logic [TICK_W-1:0] arr_rd_ff;
   logic [PRI_W-1:0]  pri_rd_ff;

   // scan unit
   logic [IDX_W-1:0]  scan_addr_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              eval_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [PRI_W-1:0]  best_pri_ff;
   logic              found_ff;
   logic [PRI_W-1:0]  cur_pri_ff;

   // run state
   logic [MAX_ENTRIES-1:0] fin_ff, fin_in;
   logic [MAX_ENTRIES-1:0] start_ff, start_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [CNT_W-1:0]       completed_ff, completed_in;

   // result register
   logic              rsp_valid_ff;
   event_type         rsp_event_ff;
   logic              rsp_run_valid_ff;
   logic [SLOT_W-1:0] rsp_run_task_ff;
   logic [SLOT_W-1:0] rsp_preempted_ff;
   logic              rsp_first_ff;
   logic              rsp_fin_ff;
   logic [TICK_W-1:0] rsp_tick_ff;
   logic              rsp_all_done_ff;

   logic [LW-1:0]     live;
   logic              slot_ok;
   logic [IDX_W-1:0]  slot_idx;
   logic              cand;
   logic              take;
   logic              commit;
   event_type         ev;
   logic              run_valid;
   logic [IDX_W-1:0]  run_idx;
   logic [IDX_W-1:0]  preempted_idx;
   logic              first;
   logic              fin_now;

   assign live     = (LW'(task_count_ff) > MAX_L) ? MAX_L : LW'(task_count_ff);
   assign slot_ok  = (LW'(slot_ff) < MAX_L);
   assign slot_idx = IDX_W'(slot_ff);
   assign commit   = cmd.commit_load | cmd.commit_tick;

   assign status.scan_last = (scan_addr_ff == LAST_IDX);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff <= req_task_slot;
         arr_ff  <= req_arrival_tick;
         pri_ff  <= req_task_priority;
         done_ff <= req_running_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
      end else if (csr_write_enable) begin
         task_count_ff <= csr_write_data;
      end
   end

   // table write on load commit, registered read at the scan address
   always_ff @(posedge clock) begin
      if (cmd.commit_load && slot_ok) begin
         arr_mem[slot_idx] <= arr_ff;
         pri_mem[slot_idx] <= pri_ff;
      end
      arr_rd_ff <= arr_mem[scan_addr_ff];
      pri_rd_ff <= pri_mem[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= 1'b0;
      end else begin
         eval_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_step && !status.scan_last) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      rd_idx_ff <= scan_addr_ff;
   end

   assign cand = eval_ff && (LW'(rd_idx_ff) < live) && !fin_ff[rd_idx_ff]
                 && (arr_rd_ff <= tick_ff);
   assign take = cand && (!found_ff || (pri_rd_ff > best_pri_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= rd_idx_ff;
         best_pri_ff <= pri_rd_ff;
      end
      if (eval_ff && (rd_idx_ff == cur_idx_ff)) begin
         cur_pri_ff <= pri_rd_ff;
      end
   end

   always_comb begin
      fin_in        = fin_ff;
      start_in      = start_ff;
      cur_idx_in    = cur_idx_ff;
      cur_valid_in  = cur_valid_ff;
      tick_in       = tick_ff;
      completed_in  = completed_ff;
      ev            = EV_LOAD;
      preempted_idx = '0;
      first         = 1'b0;
      fin_now       = 1'b0;
      run_valid     = 1'b0;
      run_idx       = '0;
      if (cmd.commit_load) begin
         if (slot_ok) begin
            if (fin_ff[slot_idx] && (completed_ff != '0)) begin
               completed_in = completed_ff - 1'b1;
            end
            fin_in[slot_idx]   = 1'b0;
            start_in[slot_idx] = 1'b0;
            if (cur_valid_ff && (cur_idx_ff == slot_idx)) begin
               cur_valid_in = 1'b0;
            end
         end
         run_valid = cur_valid_in;
         run_idx   = cur_valid_in ? cur_idx_ff : '0;
      end else if (cmd.commit_tick) begin
         if (!found_ff) begin
            ev = EV_NONE;
         end else if (cur_valid_ff && (best_pri_ff > cur_pri_ff)) begin
            ev                    = EV_PREEMPT;
            preempted_idx         = cur_idx_ff;
            first                 = !start_ff[best_idx_ff];
            start_in[best_idx_ff] = 1'b1;
            cur_idx_in            = best_idx_ff;
         end else if (!cur_valid_ff) begin
            ev                    = EV_DISPATCH;
            first                 = !start_ff[best_idx_ff];
            start_in[best_idx_ff] = 1'b1;
            cur_idx_in            = best_idx_ff;
            cur_valid_in          = 1'b1;
         end else begin
            ev = EV_CONTINUE;
         end
         run_valid = cur_valid_in;
         run_idx   = cur_valid_in ? cur_idx_in : '0;
         if (cur_valid_in && done_ff) begin
            if (!fin_ff[cur_idx_in]) begin
               fin_in[cur_idx_in] = 1'b1;
               if (completed_ff != DONE_MAX) begin
                  completed_in = completed_ff + 1'b1;
               end
            end
            cur_valid_in = 1'b0;
            fin_now      = 1'b1;
         end
         if (tick_ff != TICK_MAX) begin
            tick_in = tick_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff       <= '0;
         start_ff     <= '0;
         cur_idx_ff   <= '0;
         cur_valid_ff <= 1'b0;
         tick_ff      <= '0;
         completed_ff <= '0;
      end else if (commit) begin
         fin_ff       <= fin_in;
         start_ff     <= start_in;
         cur_idx_ff   <= cur_idx_in;
         cur_valid_ff <= cur_valid_in;
         tick_ff      <= tick_in;
         completed_ff <= completed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_event_ff     <= ev;
         rsp_run_valid_ff <= run_valid;
         rsp_run_task_ff  <= SLOT_W'(run_idx);
         rsp_preempted_ff <= SLOT_W'(preempted_idx);
         rsp_first_ff     <= first;
         rsp_fin_ff       <= fin_now;
         rsp_tick_ff      <= tick_ff;
         rsp_all_done_ff  <= (LW'(completed_in) >= live);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_code     = rsp_event_ff;
   assign rsp_running_valid  = rsp_run_valid_ff;
   assign rsp_running_task   = rsp_run_task_ff;
   assign rsp_preempted_task = rsp_preempted_ff;
   assign rsp_first_start    = rsp_first_ff;
   assign rsp_finished_valid = rsp_fin_ff;
   assign rsp_tick_now       = rsp_tick_ff;
   assign rsp_all_done       = rsp_all_done_ff;

endmodule

>>> sv/preemptive_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// load: result registered when LOAD commits, once the result register is free;
// tick: result registered when DECIDE commits after SCAN and FLUSH, also once free;
// scan is serial through the single table read port; requests taken only in IDLE
// reset clears marks, run state, tick and completion counters and task_count;
// task tables are undefined until loaded, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "preemptive_priority_scheduler_top_macros.svh"

module preemptive_priority_scheduler_top #(
   parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [pps_pkg::SLOT_W-1:0]  req_task_slot,
   input  logic [pps_pkg::TICK_W-1:0]  req_arrival_tick,
   input  logic [pps_pkg::PRI_W-1:0]   req_task_priority,
   input  logic                        req_running_done,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pps_pkg::EVENT_W-1:0] rsp_event_code,
   output logic                        rsp_running_valid,
   output logic [pps_pkg::SLOT_W-1:0]  rsp_running_task,
   output logic [pps_pkg::SLOT_W-1:0]  rsp_preempted_task,
   output logic                        rsp_first_start,
   output logic                        rsp_finished_valid,
   output logic [pps_pkg::TICK_W-1:0]  rsp_tick_now,
   output logic                        rsp_all_done,
   input  logic                        csr_write_enable,
   input  logic [pps_pkg::CNT_W-1:0]   csr_write_data
);
   import pps_pkg::*;

   cmd_type    cmd;
   status_type status;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pps_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_task_slot      (req_task_slot),
      .req_arrival_tick   (req_arrival_tick),
      .req_task_priority  (req_task_priority),
      .req_running_done   (req_running_done),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_code     (rsp_event_code),
      .rsp_running_valid  (rsp_running_valid),
      .rsp_running_task   (rsp_running_task),
      .rsp_preempted_task (rsp_preempted_task),
      .rsp_first_start    (rsp_first_start),
      .rsp_finished_valid (rsp_finished_valid),
      .rsp_tick_now       (rsp_tick_now),
      .rsp_all_done       (rsp_all_done)
   );

   `PPS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted while busy")
   `PPS_ASSERT_NOW(a_load_quiet, rsp_valid && (rsp_event_code == EV_LOAD), !rsp_first_start && !rsp_finished_valid && (rsp_preempted_task == '0), "load ack with tick fields")
   `PPS_ASSERT_NOW(a_dispatch_runs, rsp_valid && ((rsp_event_code == EV_DISPATCH) || (rsp_event_code == EV_PREEMPT)), rsp_running_valid, "dispatch without running task")
   `PPS_ASSERT_NOW(a_finish_runs, rsp_valid && rsp_finished_valid, rsp_running_valid, "finish without running task")

endmodule
